>>> hdl/mrv_pkg.sv
// Shared types and constants for the Modbus request validator.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package mrv_pkg;

    // Function codes handled by the validator
    localparam logic [7:0] FC_READ_COILS      = 8'h01;
    localparam logic [7:0] FC_READ_INPUTS     = 8'h02;
    localparam logic [7:0] FC_READ_HOLDING    = 8'h03;
    localparam logic [7:0] FC_READ_INPUT_REGS = 8'h04;
    localparam logic [7:0] FC_WRITE_COIL      = 8'h05;
    localparam logic [7:0] FC_WRITE_REG       = 8'h06;
    localparam logic [7:0] FC_WRITE_COILS     = 8'h0F;
    localparam logic [7:0] FC_WRITE_REGS      = 8'h10;

    localparam logic [7:0] FC_EXCEPTION_FLAG  = 8'h80;
    localparam logic [7:0] BROADCAST_ADDRESS  = 8'h00;
    localparam logic [7:0] ANSWER_ALL_ADDRESS = 8'h00;

    localparam logic [15:0] COIL_OFF_VALUE    = 16'h0000;
    localparam logic [15:0] COIL_ON_VALUE     = 16'hFF00;

    // Protocol maxima; a larger limit register acts as these
    localparam logic [10:0] READ_BITS_CAP_TOP   = 11'd2000;
    localparam logic [6:0]  MAX_READ_WORDS_TOP  = 7'd125;
    localparam logic [10:0] MAX_WRITE_BITS_TOP  = 11'd1968;
    localparam logic [6:0]  MAX_WRITE_WORDS_TOP = 7'd123;

    // Address space ends at 65535; start + count must not pass 65536
    localparam logic [16:0] ADDRESS_SPACE_SIZE = 17'h10000;

    localparam logic [7:0] EXC_REPLY_LENGTH   = 8'd3;
    localparam logic [7:0] WRITE_REPLY_LENGTH = 8'd6;
    localparam logic [7:0] READ_REPLY_HEADER  = 8'd3;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;

    // Reset values of the configuration registers
    localparam logic [7:0]  OWN_ADDRESS_RST     = 8'd1;
    localparam logic [5:0]  FUNCTION_ENABLE_RST = 6'h3F;
    localparam logic [10:0] READ_BITS_CAP_RST   = 11'd2000;
    localparam logic [6:0]  MAX_READ_WORDS_RST  = 7'd125;
    localparam logic [10:0] MAX_WRITE_BITS_RST  = 11'd1968;
    localparam logic [6:0]  MAX_WRITE_WORDS_RST = 7'd123;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_OWN_ADDRESS     = 3'd0,
        CFG_FUNCTION_ENABLE = 3'd1,
        CFG_READ_BITS_CAP   = 3'd2,
        CFG_MAX_READ_WORDS  = 3'd3,
        CFG_MAX_WRITE_BITS  = 3'd4,
        CFG_MAX_WRITE_WORDS = 3'd5
    } cfg_idx_t;

    // Bits of function_enable
    typedef enum logic [2:0] {
        EN_READ_COILS      = 3'd0,
        EN_READ_INPUTS     = 3'd1,
        EN_READ_HOLDING    = 3'd2,
        EN_READ_INPUT_REGS = 3'd3,
        EN_WRITE_COILS     = 3'd4,
        EN_WRITE_REGS      = 3'd5
    } en_bit_t;

    typedef enum logic [2:0] {
        EXC_NONE             = 3'd0,
        EXC_ILLEGAL_FUNCTION = 3'd1,
        EXC_ILLEGAL_ADDRESS  = 3'd2,
        EXC_ILLEGAL_VALUE    = 3'd3,
        EXC_DEVICE_FAILURE   = 3'd4
    } exc_t;

    typedef enum logic [1:0] {
        TABLE_COILS          = 2'd0,
        TABLE_DISCRETE_INPUT = 2'd1,
        TABLE_HOLDING_REGS   = 2'd2,
        TABLE_INPUT_REGS     = 2'd3
    } table_t;

    localparam logic [1:0] STORE_OK           = 2'd0;
    localparam logic [1:0] STORE_BAD_ADDRESS  = 2'd1;

    typedef struct packed {
        logic [7:0]  slave_address;
        logic [7:0]  function_code;
        logic [15:0] start_address;
        logic [15:0] quantity_or_value;
        logic [7:0]  declared_byte_count;
        logic [1:0]  store_status;
    } req_t;

    typedef struct packed {
        logic        respond;
        logic        is_exception;
        logic [2:0]  exception_code;
        logic [7:0]  reply_function;
        logic [7:0]  reply_length;
        logic [7:0]  reply_byte_count;
        logic        access_valid;
        logic [1:0]  access_table;
        logic        access_write;
        logic [15:0] access_start;
        logic [10:0] access_count;
    } rsp_t;

    typedef struct packed {
        logic [7:0]  own_address;
        logic [5:0]  function_enable;
        logic [10:0] read_bits_cap;
        logic [6:0]  max_read_words;
        logic [10:0] max_write_bits;
        logic [6:0]  max_write_words;
    } cfg_t;

endpackage

`default_nettype wire

>>> hdl/mrv_if.sv
// Valid/ready stream interfaces for request headers and reply headers.
// Depends on mrv_pkg for the payload structs.
`default_nettype none

interface mrv_req_if
    import mrv_pkg::*;
;
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mrv_rsp_if
    import mrv_pkg::*;
;
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/mrv_check.sv
// Combinational request check: address filter, function decode, limits,
// coil encoding, address overflow and store verdict. Uses mrv_pkg.
`default_nettype none

module mrv_check
    import mrv_pkg::*;
(
    input  var req_t req,
    input  var cfg_t cfg,
    output rsp_t     rsp
);

    always_comb
    begin
        logic        match;
        logic        known;
        logic        multi;
        logic        wr;
        logic        bit_read;
        en_bit_t     en_bit;
        table_t      tbl;
        logic [10:0] limit;
        logic [10:0] rb_lim;
        logic [10:0] wb_lim;
        logic [6:0]  rw_lim;
        logic [6:0]  ww_lim;
        logic [15:0] count;
        logic [16:0] qty_plus7;
        logic [13:0] bit_bytes;
        logic [16:0] word_bytes;
        logic [16:0] end_addr;
        logic [7:0]  nbytes;
        exc_t        exc;

        match = (cfg.own_address == ANSWER_ALL_ADDRESS)
             || (req.slave_address == BROADCAST_ADDRESS)
             || (req.slave_address == cfg.own_address);

        rb_lim = (cfg.read_bits_cap > READ_BITS_CAP_TOP) ? READ_BITS_CAP_TOP
                                                         : cfg.read_bits_cap;
        wb_lim = (cfg.max_write_bits > MAX_WRITE_BITS_TOP) ? MAX_WRITE_BITS_TOP
                                                           : cfg.max_write_bits;
        rw_lim = (cfg.max_read_words > MAX_READ_WORDS_TOP) ? MAX_READ_WORDS_TOP
                                                           : cfg.max_read_words;
        ww_lim = (cfg.max_write_words > MAX_WRITE_WORDS_TOP) ? MAX_WRITE_WORDS_TOP
                                                             : cfg.max_write_words;

        known  = 1'b1;
        multi  = 1'b0;
        wr     = 1'b0;
        en_bit = EN_READ_COILS;
        tbl    = TABLE_COILS;
        limit  = '0;
        unique case (req.function_code)
            FC_READ_COILS:
            begin
                en_bit = EN_READ_COILS;      tbl = TABLE_COILS;
                limit = rb_lim;              multi = 1'b1;
            end
            FC_READ_INPUTS:
            begin
                en_bit = EN_READ_INPUTS;     tbl = TABLE_DISCRETE_INPUT;
                limit = rb_lim;              multi = 1'b1;
            end
            FC_READ_HOLDING:
            begin
                en_bit = EN_READ_HOLDING;    tbl = TABLE_HOLDING_REGS;
                limit = {4'b0, rw_lim};      multi = 1'b1;
            end
            FC_READ_INPUT_REGS:
            begin
                en_bit = EN_READ_INPUT_REGS; tbl = TABLE_INPUT_REGS;
                limit = {4'b0, rw_lim};      multi = 1'b1;
            end
            FC_WRITE_COIL:
            begin
                en_bit = EN_WRITE_COILS;     tbl = TABLE_COILS;          wr = 1'b1;
            end
            FC_WRITE_REG:
            begin
                en_bit = EN_WRITE_REGS;      tbl = TABLE_HOLDING_REGS;   wr = 1'b1;
            end
            FC_WRITE_COILS:
            begin
                en_bit = EN_WRITE_COILS;     tbl = TABLE_COILS;          wr = 1'b1;
                limit = wb_lim;              multi = 1'b1;
            end
            FC_WRITE_REGS:
            begin
                en_bit = EN_WRITE_REGS;      tbl = TABLE_HOLDING_REGS;   wr = 1'b1;
                limit = {4'b0, ww_lim};      multi = 1'b1;
            end
            default:
            begin
                known = 1'b0;
            end
        endcase

        count      = multi ? req.quantity_or_value : 16'd1;
        qty_plus7  = {1'b0, count} + 17'd7;
        bit_bytes  = qty_plus7[16:3];
        word_bytes = {count, 1'b0};
        end_addr   = {1'b0, req.start_address} + {1'b0, count};

        exc = EXC_NONE;
        if (!known || !cfg.function_enable[en_bit])
            exc = EXC_ILLEGAL_FUNCTION;
        else if (multi)
        begin
            if (count == 16'd0 || count > {5'b0, limit})
                exc = EXC_ILLEGAL_VALUE;
            else if (req.function_code == FC_WRITE_COILS
                     && bit_bytes != {6'b0, req.declared_byte_count})
                exc = EXC_ILLEGAL_VALUE;
            else if (req.function_code == FC_WRITE_REGS
                     && word_bytes != {9'b0, req.declared_byte_count})
                exc = EXC_ILLEGAL_VALUE;
            else if (end_addr > ADDRESS_SPACE_SIZE)
                exc = EXC_ILLEGAL_ADDRESS;
        end
        else if (req.function_code == FC_WRITE_COIL
                 && req.quantity_or_value != COIL_OFF_VALUE
                 && req.quantity_or_value != COIL_ON_VALUE)
            exc = EXC_ILLEGAL_VALUE;

        if (exc == EXC_NONE)
        begin
            if (req.store_status == STORE_BAD_ADDRESS)
                exc = EXC_ILLEGAL_ADDRESS;
            else if (req.store_status != STORE_OK)
                exc = EXC_DEVICE_FAILURE;
        end

        // Read bytes stay below 256 once the limit check has passed
        bit_read = (req.function_code == FC_READ_COILS)
                || (req.function_code == FC_READ_INPUTS);
        nbytes   = wr ? 8'd0 : (bit_read ? bit_bytes[7:0] : word_bytes[7:0]);

        rsp = '0;
        if (match)
        begin
            rsp.respond = 1'b1;
            if (exc != EXC_NONE)
            begin
                rsp.is_exception   = 1'b1;
                rsp.exception_code = exc;
                rsp.reply_function = req.function_code | FC_EXCEPTION_FLAG;
                rsp.reply_length   = EXC_REPLY_LENGTH;
            end
            else
            begin
                rsp.reply_function   = req.function_code;
                rsp.reply_length     = wr ? WRITE_REPLY_LENGTH
                                          : nbytes + READ_REPLY_HEADER;
                rsp.reply_byte_count = nbytes;
                rsp.access_valid     = 1'b1;
                rsp.access_table     = tbl;
                rsp.access_write     = wr;
                rsp.access_start     = req.start_address;
                rsp.access_count     = count[10:0];
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/modbus_request_validator.sv
// Top level of the Modbus request validator: config registers, input and
// result registers around mrv_check. Uses mrv_pkg and mrv_if.
//
//  port    dir   kind          transaction
//  req     in    valid/ready   one parsed request header + store verdict
//  rsp     out   valid/ready   one reply header + store access command
//  cfg_*   in    write only    one register write, index 0..5
//
// rsp valid follows req accept through the input and result registers;
// one request per cycle while rsp is not stalled. The rate is set by the
// single pass through mrv_check between the input register and the result
// register. Each request yields exactly one rsp, with respond low when it
// is not addressed here. A stalled rsp holds its data; the input register
// accepts while it is empty or while the result register is free or being
// drained. Reset loads the config defaults and empties both stages.
`default_nettype none

module modbus_request_validator
    import mrv_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    mrv_req_if.sink                     req,
    mrv_rsp_if.source                   rsp,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_t cfg_reg;
    logic s1_valid_reg;
    req_t s1_data_reg;
    logic out_valid_reg;
    rsp_t out_data_reg;
    rsp_t out_data_next;
    logic s1_advance;
    logic out_free;

    assign out_free   = !out_valid_reg || rsp.ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign req.ready  = !s1_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_address     <= OWN_ADDRESS_RST;
            cfg_reg.function_enable <= FUNCTION_ENABLE_RST;
            cfg_reg.read_bits_cap   <= READ_BITS_CAP_RST;
            cfg_reg.max_read_words  <= MAX_READ_WORDS_RST;
            cfg_reg.max_write_bits  <= MAX_WRITE_BITS_RST;
            cfg_reg.max_write_words <= MAX_WRITE_WORDS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_OWN_ADDRESS:     cfg_reg.own_address     <= cfg_wdata[7:0];
                CFG_FUNCTION_ENABLE: cfg_reg.function_enable <= cfg_wdata[5:0];
                CFG_READ_BITS_CAP:   cfg_reg.read_bits_cap   <= cfg_wdata[10:0];
                CFG_MAX_READ_WORDS:  cfg_reg.max_read_words  <= cfg_wdata[6:0];
                CFG_MAX_WRITE_BITS:  cfg_reg.max_write_bits  <= cfg_wdata[10:0];
                CFG_MAX_WRITE_WORDS: cfg_reg.max_write_words <= cfg_wdata[6:0];
                default:
                begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
                s1_valid_reg <= req.valid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
            s1_data_reg <= req.data;
        if (s1_advance)
            out_data_reg <= out_data_next;
    end

    mrv_check u_check (
        .req (s1_data_reg),
        .cfg (cfg_reg),
        .rsp (out_data_next)
    );

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // An accepted transaction always lands in the input register
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> s1_valid_reg)
        else $error("accepted request lost before input register");

    // A request leaving the input register always reaches the result register
    a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> out_valid_reg)
        else $error("checked request lost before result register");

    // Ignored requests carry an all-zero result
    a_ignore_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.respond |-> out_data_reg == '0)
        else $error("ignored request has nonzero result fields");

    // Exception replies are short, flagged and start no store access
    a_exc_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.is_exception |->
            out_data_reg.respond && !out_data_reg.access_valid
            && out_data_reg.reply_function[7]
            && out_data_reg.reply_length == EXC_REPLY_LENGTH)
        else $error("malformed exception reply");

endmodule

`default_nettype wire
